// ----- hw/rtl/tsps_pkg.sv -----
// shared types and constants for the time slice priority scheduler
// no dependencies; used by tsps_scan and time_slice_priority_scheduler_core
`timescale 1ns / 1ps

package tsps_pkg;

  // fixed field widths
  localparam int unsigned TaskW    = 3;
  localparam int unsigned CountW   = 4;
  localparam int unsigned NumWork  = 7;
  localparam int unsigned CfgIdxW  = 3;

  // controls from the sequencer into the scan unit
  typedef struct packed {
    logic clear;
    logic step;
  } scan_ctrl_t;

  // scan unit status back to the sequencer
  typedef struct packed {
    logic             last;
    logic [TaskW-1:0] best_idx;
  } scan_stat_t;

endpackage

// ----- hw/rtl/tsps_scan.sv -----
// scan unit: walks the task counters one per cycle while step is high, with one shared compare
// depends on tsps_pkg
`timescale 1ns / 1ps

module tsps_scan #(
  parameter int unsigned TASK_COUNT = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  tsps_pkg::scan_ctrl_t            ctrl_i,
  input  logic [tsps_pkg::CountW-1:0]     value_i,
  output logic [tsps_pkg::TaskW-1:0]      rd_idx_o,
  output tsps_pkg::scan_stat_t            stat_o
);

  logic [tsps_pkg::TaskW-1:0]  idx_q, idx_d;
  logic [tsps_pkg::TaskW-1:0]  best_idx_q, best_idx_d;
  logic [tsps_pkg::CountW-1:0] best_val_q, best_val_d;
  logic                        greater;

  // shared compare: strictly larger keeps ties on the lowest index
  assign greater = value_i > best_val_q;

  // walk state
  always_comb begin
    idx_d      = idx_q;
    best_idx_d = best_idx_q;
    best_val_d = best_val_q;
    if (ctrl_i.clear) begin
      idx_d      = tsps_pkg::TaskW'(1);
      best_idx_d = '0;
      best_val_d = '0;
    end else if (ctrl_i.step) begin
      idx_d = idx_q + tsps_pkg::TaskW'(1);
      if (greater) begin
        best_idx_d = idx_q;
        best_val_d = value_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= tsps_pkg::TaskW'(1);
      best_idx_q <= '0;
      best_val_q <= '0;
    end else begin
      idx_q      <= idx_d;
      best_idx_q <= best_idx_d;
      best_val_q <= best_val_d;
    end
  end

  assign rd_idx_o        = idx_q;
  assign stat_o.last     = (idx_q == tsps_pkg::TaskW'(TASK_COUNT - 1));
  assign stat_o.best_idx = best_idx_q;

endmodule

// ----- hw/rtl/time_slice_priority_scheduler_core.sv -----
// top level of the time slice priority scheduler: sequencer, counters, priorities
// depends on tsps_pkg and tsps_scan
`timescale 1ns / 1ps

// Usage:
// A tick request is taken at a rising edge with start_i high and busy_o low.
// tick_i of one runs the scheduler step; tick_i of zero just reports the
// running task and its slice. Each request gives one result on running_task_o,
// switched_o, reloaded_o and slice_left_o, valid for the single cycle in which
// done_o is high; the receiver cannot stall, so it must sample then.
// Sequence: StDec updates the running counter; when a reschedule is due, a pass
// through the shared compare unit (StScan) and StEval follow, and when every
// counter is zero StReload reloads them and a second pass and StEval follow;
// StResp then gives the result. A zero tick goes straight to StResp. busy_o
// stays high over all of it, so requests run one at a time.
// The priority registers are written over cfg_valid_i/cfg_ready_o; the user
// must write them only while the block is idle, which the block does not enforce;
// cfg_ready_o is always high and indexes above six are ignored.
// Reset sets all priorities to one, all counters to zero and the idle task.
module time_slice_priority_scheduler_core #(
  parameter int unsigned TASK_COUNT = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // tick request
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic                             tick_i,
  // result
  output logic                             done_o,
  output logic [tsps_pkg::TaskW-1:0]       running_task_o,
  output logic                             switched_o,
  output logic                             reloaded_o,
  output logic [tsps_pkg::CountW-1:0]      slice_left_o,
  // priority register writes
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [tsps_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [tsps_pkg::CountW-1:0]      cfg_data_i
);

  typedef enum logic [5:0] {
    StIdle   = 6'b000001,
    StDec    = 6'b000010,
    StScan   = 6'b000100,
    StEval   = 6'b001000,
    StReload = 6'b010000,
    StResp   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [tsps_pkg::CountW-1:0] prio_q [tsps_pkg::NumWork];
  logic [tsps_pkg::CountW-1:0] cnt_q  [tsps_pkg::NumWork];
  logic [tsps_pkg::TaskW-1:0]  cur_q, cur_d;
  logic                        switched_q, switched_d;
  logic                        reloaded_q, reloaded_d;

  tsps_pkg::scan_ctrl_t        scan_ctrl;
  tsps_pkg::scan_stat_t        scan_stat;
  logic [tsps_pkg::TaskW-1:0]  scan_idx;

  logic [tsps_pkg::TaskW-1:0]  rd_task;
  logic [tsps_pkg::TaskW-1:0]  rd_addr;
  logic [tsps_pkg::CountW-1:0] rd_cnt;
  logic                        dec_wr;
  logic                        reload_wr;
  logic                        accept;

  assign accept      = start_i && !busy_o;
  assign busy_o      = (state_q != StIdle);
  assign cfg_ready_o = 1'b1;

  // single counter read port: scan index during a pass, else the running task
  assign rd_task = (state_q == StScan) ? scan_idx : cur_q;
  assign rd_addr = rd_task - tsps_pkg::TaskW'(1);
  assign rd_cnt  = (rd_task == '0) ? '0 : cnt_q[rd_addr];

  tsps_scan #(
    .TASK_COUNT(TASK_COUNT)
  ) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (scan_ctrl),
    .value_i (rd_cnt),
    .rd_idx_o(scan_idx),
    .stat_o  (scan_stat)
  );

  // sequencer
  always_comb begin
    state_d         = state_q;
    cur_d           = cur_q;
    switched_d      = switched_q;
    reloaded_d      = reloaded_q;
    scan_ctrl.clear = 1'b0;
    scan_ctrl.step  = 1'b0;
    dec_wr          = 1'b0;
    reload_wr       = 1'b0;
    case (state_q)
      StIdle: begin
        if (accept) begin
          switched_d = 1'b0;
          reloaded_d = 1'b0;
          state_d    = tick_i ? StDec : StResp;
        end
      end
      StDec: begin
        if (cur_q == '0 || rd_cnt == '0) begin
          scan_ctrl.clear = 1'b1;
          state_d         = StScan;
        end else begin
          dec_wr = 1'b1;
          if (rd_cnt == tsps_pkg::CountW'(1)) begin
            scan_ctrl.clear = 1'b1;
            state_d         = StScan;
          end else begin
            state_d = StResp;
          end
        end
      end
      StScan: begin
        scan_ctrl.step = 1'b1;
        if (scan_stat.last) begin
          state_d = StEval;
        end
      end
      StEval: begin
        if (scan_stat.best_idx == '0 && !reloaded_q) begin
          state_d = StReload;
        end else begin
          switched_d = (scan_stat.best_idx != cur_q);
          cur_d      = scan_stat.best_idx;
          state_d    = StResp;
        end
      end
      StReload: begin
        reload_wr       = 1'b1;
        reloaded_d      = 1'b1;
        scan_ctrl.clear = 1'b1;
        state_d         = StScan;
      end
      StResp: begin
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      cur_q      <= '0;
      switched_q <= 1'b0;
      reloaded_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cur_q      <= cur_d;
      switched_q <= switched_d;
      reloaded_q <= reloaded_d;
    end
  end

  // priority registers and slice counters
  for (genvar i = 0; i < tsps_pkg::NumWork; i++) begin : g_task
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        prio_q[i] <= tsps_pkg::CountW'(1);
      end else if (cfg_valid_i && cfg_ready_o &&
                   cfg_index_i == tsps_pkg::CfgIdxW'(i)) begin
        prio_q[i] <= cfg_data_i;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cnt_q[i] <= '0;
      end else if (reload_wr && (i + 1 < TASK_COUNT)) begin
        cnt_q[i] <= prio_q[i];
      end else if (dec_wr && rd_addr == tsps_pkg::TaskW'(i)) begin
        cnt_q[i] <= rd_cnt - tsps_pkg::CountW'(1);
      end
    end
  end

  // result, shown for the one response cycle
  assign done_o         = (state_q == StResp);
  assign running_task_o = cur_q;
  assign switched_o     = switched_q;
  assign reloaded_o     = reloaded_q;
  assign slice_left_o   = rd_cnt;

endmodule
